[hdl/owdm_pkg.sv]
// ----------------------------------------------------------------------------
// owdm_pkg
// Shared types, constants and elaboration-time trig functions for the
// omni wheel drive mixer.
// ----------------------------------------------------------------------------
package owdm_pkg;

	// defaults for the top-level parameters
	localparam int DUTY_MAX_DEF       = 255;
	localparam int TRIG_FRAC_BITS_DEF = 14;

	// field and register widths
	localparam int HEADING_W = 12;
	localparam int ARM_W     = 16;
	localparam int RATE_W    = 16;
	localparam int CFG_W     = 16;
	localparam int DUTY_W    = 8;
	localparam int CFG_IDX_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ARM_LENGTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_RATE = 2'd1;

	localparam logic [ARM_W-1:0]  ARM_LENGTH_RST    = 16'd256;
	localparam logic [RATE_W-1:0] ROTATION_RATE_RST = 16'd0;

	// angle handling, all in tenths of a degree
	localparam int ANGLE_W      = 12;
	localparam int REM_W        = 10;
	localparam int ANGLE_OFFSET = 450;
	localparam int FULL_TURN    = 3600;
	localparam int QUARTER_TURN = 900;
	localparam int EIGHTH_TURN  = 450;

	// sine/cosine table over one octant, 0..450 tenths inclusive
	localparam int TABLE_DEPTH = EIGHTH_TURN + 1;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	// wheel value: trig << (ONE_SHIFT - frac) + arm * rate, 1.0 == 2^ONE_SHIFT
	localparam int ONE_SHIFT   = 22;
	localparam int ROT_W       = ARM_W + 1 + RATE_W;
	localparam int SUM_W       = ROT_W + 1;
	localparam int DUTY_CALC_W = 16;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	// load strobes for the two register stages a unit owns
	typedef struct packed {
		logic ld_a;
		logic ld_b;
	} owdm_ld_t;

	// folded angle handed from the angle unit to the trig unit
	typedef struct packed {
		logic [1:0]       quad;
		logic             swap;
		logic [IDX_W-1:0] idx;
	} owdm_fold_t;

	function automatic longint unsigned angle_q30(input int t);
		longint unsigned tu;
		tu = longint'(t);
		return (tu * PI_Q30 + 64'd900) / 64'd1800;
	endfunction

	// clamp to [0, 1.0] and round half up to frac fraction bits
	function automatic logic [31:0] trig_round(input longint s, input int frac);
		longint v;
		v = s;
		if (v < 0)
			v = 0;
		if (v > longint'(ONE_Q30))
			v = longint'(ONE_Q30);
		return 32'((v + (64'sd1 <<< (29 - frac))) >>> (30 - frac));
	endfunction

	function automatic logic [31:0] octant_sin(input int t, input int frac);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint s;
		x    = angle_q30(t);
		x2   = (x * x) >> 30;
		term = x;
		s    = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;   s = s - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;  s = s + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;  s = s - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;  s = s + longint'(term);
		term = ((term * x2) >> 30) / 64'd110; s = s - longint'(term);
		term = ((term * x2) >> 30) / 64'd156; s = s + longint'(term);
		return trig_round(s, frac);
	endfunction

	function automatic logic [31:0] octant_cos(input int t, input int frac);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint s;
		x    = angle_q30(t);
		x2   = (x * x) >> 30;
		term = ONE_Q30;
		s    = longint'(ONE_Q30);
		term = ((term * x2) >> 30) / 64'd2;   s = s - longint'(term);
		term = ((term * x2) >> 30) / 64'd12;  s = s + longint'(term);
		term = ((term * x2) >> 30) / 64'd30;  s = s - longint'(term);
		term = ((term * x2) >> 30) / 64'd56;  s = s + longint'(term);
		term = ((term * x2) >> 30) / 64'd90;  s = s - longint'(term);
		term = ((term * x2) >> 30) / 64'd132; s = s + longint'(term);
		return trig_round(s, frac);
	endfunction

endpackage

[hdl/owdm_angle.sv]
// ----------------------------------------------------------------------------
// owdm_angle
// Heading offset and wrap, then quadrant split and octant fold (two stages).
// ----------------------------------------------------------------------------
module owdm_angle (
	input  logic                                  clk,
	input  owdm_pkg::owdm_ld_t                    ld,
	input  logic [owdm_pkg::HEADING_W-1:0]        heading,
	output owdm_pkg::owdm_fold_t                  fold
);

	logic signed [owdm_pkg::HEADING_W:0] a_raw;
	logic [owdm_pkg::ANGLE_W-1:0]        a_wrap;
	logic [owdm_pkg::ANGLE_W-1:0]        angle_s1;
	logic [1:0]                          quad;
	logic [owdm_pkg::ANGLE_W-1:0]        rem_full;
	logic [owdm_pkg::REM_W-1:0]          rem;
	owdm_pkg::owdm_fold_t                fold_d;
	owdm_pkg::owdm_fold_t                fold_s2;

	// stage 1: turn by -45 degrees and wrap into one turn
	always_comb begin
		a_raw = $signed({1'b0, heading}) - (owdm_pkg::HEADING_W+1)'(owdm_pkg::ANGLE_OFFSET);
		if (a_raw < 0) begin
			a_wrap = owdm_pkg::ANGLE_W'(a_raw + (owdm_pkg::HEADING_W+1)'(owdm_pkg::FULL_TURN));
		end else if (a_raw >= (owdm_pkg::HEADING_W+1)'(owdm_pkg::FULL_TURN)) begin
			a_wrap = owdm_pkg::ANGLE_W'(a_raw - (owdm_pkg::HEADING_W+1)'(owdm_pkg::FULL_TURN));
		end else begin
			a_wrap = owdm_pkg::ANGLE_W'(a_raw);
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_a) begin
			angle_s1 <= a_wrap;
		end
	end

	// stage 2: quadrant and remainder, fold the upper half of the quadrant
	always_comb begin
		priority if (angle_s1 >= owdm_pkg::ANGLE_W'(3 * owdm_pkg::QUARTER_TURN)) begin
			quad     = 2'd3;
			rem_full = angle_s1 - owdm_pkg::ANGLE_W'(3 * owdm_pkg::QUARTER_TURN);
		end else if (angle_s1 >= owdm_pkg::ANGLE_W'(2 * owdm_pkg::QUARTER_TURN)) begin
			quad     = 2'd2;
			rem_full = angle_s1 - owdm_pkg::ANGLE_W'(2 * owdm_pkg::QUARTER_TURN);
		end else if (angle_s1 >= owdm_pkg::ANGLE_W'(owdm_pkg::QUARTER_TURN)) begin
			quad     = 2'd1;
			rem_full = angle_s1 - owdm_pkg::ANGLE_W'(owdm_pkg::QUARTER_TURN);
		end else begin
			quad     = 2'd0;
			rem_full = angle_s1;
		end
		rem         = rem_full[owdm_pkg::REM_W-1:0];
		fold_d.quad = quad;
		if (rem > owdm_pkg::REM_W'(owdm_pkg::EIGHTH_TURN)) begin
			fold_d.swap = 1'b1;
			fold_d.idx  = owdm_pkg::IDX_W'(owdm_pkg::REM_W'(owdm_pkg::QUARTER_TURN) - rem);
		end else begin
			fold_d.swap = 1'b0;
			fold_d.idx  = rem[owdm_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_b) begin
			fold_s2 <= fold_d;
		end
	end

	assign fold = fold_s2;

endmodule

[hdl/owdm_trig.sv]
// ----------------------------------------------------------------------------
// owdm_trig
// Octant sine/cosine table read and quadrant sign placement (two stages).
// ----------------------------------------------------------------------------
module owdm_trig #(
	parameter int TRIG_FRAC_BITS = owdm_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  owdm_pkg::owdm_ld_t            ld,
	input  owdm_pkg::owdm_fold_t          fold,
	output logic signed [TRIG_FRAC_BITS+1:0] cx,
	output logic signed [TRIG_FRAC_BITS+1:0] sy
);

	localparam int TRIG_W = TRIG_FRAC_BITS + 1;

	logic [2*TRIG_W-1:0]              rom [owdm_pkg::TABLE_DEPTH];
	logic [2*TRIG_W-1:0]              entry_s3;
	logic [1:0]                       quad_s3;
	logic                             swap_s3;
	logic [TRIG_W-1:0]                s0;
	logic [TRIG_W-1:0]                c0;
	logic signed [TRIG_W:0]           s0_p;
	logic signed [TRIG_W:0]           c0_p;
	logic signed [TRIG_W:0]           cx_d;
	logic signed [TRIG_W:0]           sy_d;
	logic signed [TRIG_W:0]           cx_s4;
	logic signed [TRIG_W:0]           sy_s4;

	// table contents: {sin, cos} per tenth of a degree over one octant
	for (genvar i = 0; i < owdm_pkg::TABLE_DEPTH; i++) begin : g_rom
		assign rom[i] = {TRIG_W'(owdm_pkg::octant_sin(i, TRIG_FRAC_BITS)),
			TRIG_W'(owdm_pkg::octant_cos(i, TRIG_FRAC_BITS))};
	end

	// stage 3: registered table read
	always_ff @(posedge clk) begin
		if (ld.ld_a) begin
			entry_s3 <= rom[fold.idx];
			quad_s3  <= fold.quad;
			swap_s3  <= fold.swap;
		end
	end

	// stage 4: undo the fold, then place signs by quadrant
	always_comb begin
		if (swap_s3) begin
			s0 = entry_s3[TRIG_W-1:0];
			c0 = entry_s3[2*TRIG_W-1:TRIG_W];
		end else begin
			s0 = entry_s3[2*TRIG_W-1:TRIG_W];
			c0 = entry_s3[TRIG_W-1:0];
		end
		s0_p = $signed({1'b0, s0});
		c0_p = $signed({1'b0, c0});
		unique case (quad_s3)
			2'd0: begin
				cx_d = c0_p;
				sy_d = s0_p;
			end
			2'd1: begin
				cx_d = -s0_p;
				sy_d = c0_p;
			end
			2'd2: begin
				cx_d = -c0_p;
				sy_d = -s0_p;
			end
			default: begin
				cx_d = s0_p;
				sy_d = -c0_p;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld.ld_b) begin
			cx_s4 <= cx_d;
			sy_s4 <= sy_d;
		end
	end

	assign cx = cx_s4;
	assign sy = sy_s4;

endmodule

[hdl/owdm_wheel.sv]
// ----------------------------------------------------------------------------
// owdm_wheel
// One wheel lane: add rotation term, take sign and magnitude, scale to duty.
// ----------------------------------------------------------------------------
module owdm_wheel #(
	parameter int TRIG_FRAC_BITS = owdm_pkg::TRIG_FRAC_BITS_DEF,
	parameter int DUTY_MAX       = owdm_pkg::DUTY_MAX_DEF
) (
	input  logic                                 clk,
	input  owdm_pkg::owdm_ld_t                   ld,
	input  logic signed [TRIG_FRAC_BITS+1:0]     trig,
	input  logic                                 negate,
	input  logic signed [owdm_pkg::ROT_W-1:0]    rot,
	output logic [owdm_pkg::DUTY_W-1:0]          duty,
	output logic                                 reverse
);

	localparam int TRIG_SHIFT = owdm_pkg::ONE_SHIFT - TRIG_FRAC_BITS;
	localparam int PROD_W     = owdm_pkg::ONE_SHIFT + owdm_pkg::DUTY_CALC_W;

	logic signed [TRIG_FRAC_BITS+1:0]     term;
	logic signed [owdm_pkg::SUM_W-1:0]    sum;
	logic [owdm_pkg::SUM_W-1:0]           mag;
	logic [owdm_pkg::ONE_SHIFT-1:0]       mag_s5;
	logic                                 sat_s5;
	logic                                 rev_s5;
	logic [PROD_W-1:0]                    prod;
	logic [owdm_pkg::DUTY_CALC_W-1:0]     duty_full;
	logic [owdm_pkg::DUTY_W-1:0]          duty_s6;
	logic                                 rev_s6;

	// stage 5: wheel value with 1.0 at bit ONE_SHIFT
	always_comb begin
		term = negate ? -trig : trig;
		sum  = (owdm_pkg::SUM_W'(term) <<< TRIG_SHIFT) + owdm_pkg::SUM_W'(rot);
		mag  = (sum < 0) ? owdm_pkg::SUM_W'(-sum) : owdm_pkg::SUM_W'(sum);
	end

	always_ff @(posedge clk) begin
		if (ld.ld_a) begin
			mag_s5 <= mag[owdm_pkg::ONE_SHIFT-1:0];
			sat_s5 <= |mag[owdm_pkg::SUM_W-1:owdm_pkg::ONE_SHIFT];
			rev_s5 <= sum < 0;
		end
	end

	// stage 6: scale fraction to duty, saturate at full scale
	always_comb begin
		prod = PROD_W'(mag_s5) * PROD_W'(owdm_pkg::DUTY_CALC_W'(DUTY_MAX));
		if (sat_s5) begin
			duty_full = owdm_pkg::DUTY_CALC_W'(DUTY_MAX);
		end else begin
			duty_full = prod[PROD_W-1:owdm_pkg::ONE_SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_b) begin
			duty_s6 <= duty_full[owdm_pkg::DUTY_W-1:0];
			rev_s6  <= rev_s5;
		end
	end

	assign duty    = duty_s6;
	assign reverse = rev_s6;

endmodule

[hdl/omni_wheel_drive_mixer.sv]
// ----------------------------------------------------------------------------
// omni_wheel_drive_mixer
// Four-wheel omni base inverse kinematics: heading in, four duty/direction
// pairs out.
// ----------------------------------------------------------------------------
// The block accepts one heading per clock while in_stall is low and returns
// one result per heading. The six pipeline registers are: angle wrap, quadrant
// fold, table read (the octant sine/cosine table has a registered read port),
// quadrant signs, wheel sum and magnitude, duty scaling. Stalls on the output
// ripple back stage by stage, so empty stages fill while the head is held;
// in_stall goes high only when all six stages hold transactions and out_stall
// is high. arm_length and rotation_rate are multiplied into a registered
// rotation term the cycle after a write, so write them only while no
// transaction is in flight. Index values beyond rotation_rate are ignored.
module omni_wheel_drive_mixer #(
	parameter int DUTY_MAX       = owdm_pkg::DUTY_MAX_DEF,
	parameter int TRIG_FRAC_BITS = owdm_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [owdm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [owdm_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [owdm_pkg::HEADING_W-1:0]        heading_tenths,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [owdm_pkg::DUTY_W-1:0]           duty_wheel0,
	output logic                                  reverse_wheel0,
	output logic [owdm_pkg::DUTY_W-1:0]           duty_wheel1,
	output logic                                  reverse_wheel1,
	output logic [owdm_pkg::DUTY_W-1:0]           duty_wheel2,
	output logic                                  reverse_wheel2,
	output logic [owdm_pkg::DUTY_W-1:0]           duty_wheel3,
	output logic                                  reverse_wheel3
);

	logic [owdm_pkg::ARM_W-1:0]           arm_length_q;
	logic [owdm_pkg::RATE_W-1:0]          rotation_rate_q;
	logic signed [owdm_pkg::ROT_W-1:0]    rot_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	owdm_pkg::owdm_ld_t   ld_angle;
	owdm_pkg::owdm_ld_t   ld_trig;
	owdm_pkg::owdm_ld_t   ld_wheel;
	owdm_pkg::owdm_fold_t fold;

	logic signed [TRIG_FRAC_BITS+1:0] cx;
	logic signed [TRIG_FRAC_BITS+1:0] sy;

	// configuration registers; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_length_q    <= owdm_pkg::ARM_LENGTH_RST;
			rotation_rate_q <= owdm_pkg::ROTATION_RATE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				owdm_pkg::REG_ARM_LENGTH:    arm_length_q    <= cfg_data;
				owdm_pkg::REG_ROTATION_RATE: rotation_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// rotation term, shared by all four wheels; registered from the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= '0;
		end else begin
			rot_q <= $signed({1'b0, arm_length_q}) * $signed(rotation_rate_q);
		end
	end

	// advance a stage when it is empty or the stage after it advances
	assign adv6 = !vld_s6 || !out_stall;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;

	assign in_stall  = !adv1;
	assign out_valid = vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	assign ld_angle = '{ld_a: adv1, ld_b: adv2};
	assign ld_trig  = '{ld_a: adv3, ld_b: adv4};
	assign ld_wheel = '{ld_a: adv5, ld_b: adv6};

	owdm_angle u_angle (
		.clk     (clk),
		.ld      (ld_angle),
		.heading (heading_tenths),
		.fold    (fold)
	);

	owdm_trig #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_trig (
		.clk  (clk),
		.ld   (ld_trig),
		.fold (fold),
		.cx   (cx),
		.sy   (sy)
	);

	// wheels at 0, 90, 180 and 270 degrees take y, -x, -y, x
	owdm_wheel #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.DUTY_MAX       (DUTY_MAX)
	) u_wheel0 (
		.clk     (clk),
		.ld      (ld_wheel),
		.trig    (sy),
		.negate  (1'b0),
		.rot     (rot_q),
		.duty    (duty_wheel0),
		.reverse (reverse_wheel0)
	);

	owdm_wheel #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.DUTY_MAX       (DUTY_MAX)
	) u_wheel1 (
		.clk     (clk),
		.ld      (ld_wheel),
		.trig    (cx),
		.negate  (1'b1),
		.rot     (rot_q),
		.duty    (duty_wheel1),
		.reverse (reverse_wheel1)
	);

	owdm_wheel #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.DUTY_MAX       (DUTY_MAX)
	) u_wheel2 (
		.clk     (clk),
		.ld      (ld_wheel),
		.trig    (sy),
		.negate  (1'b1),
		.rot     (rot_q),
		.duty    (duty_wheel2),
		.reverse (reverse_wheel2)
	);

	owdm_wheel #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.DUTY_MAX       (DUTY_MAX)
	) u_wheel3 (
		.clk     (clk),
		.ld      (ld_wheel),
		.trig    (cx),
		.negate  (1'b0),
		.rot     (rot_q),
		.duty    (duty_wheel3),
		.reverse (reverse_wheel3)
	);

endmodule

[hdl/owdm_checker.sv]
// ----------------------------------------------------------------------------
// owdm_checker
// Port-level checks on the mixer's handshakes and pipeline occupancy.
// ----------------------------------------------------------------------------
module owdm_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic [owdm_pkg::DUTY_W-1:0]           duty_wheel0,
	input  logic                                  reverse_wheel0,
	input  logic [owdm_pkg::DUTY_W-1:0]           duty_wheel1,
	input  logic                                  reverse_wheel1,
	input  logic [owdm_pkg::DUTY_W-1:0]           duty_wheel2,
	input  logic                                  reverse_wheel2,
	input  logic [owdm_pkg::DUTY_W-1:0]           duty_wheel3,
	input  logic                                  reverse_wheel3
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a held result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(duty_wheel0) && $stable(reverse_wheel0)
			&& $stable(duty_wheel1) && $stable(reverse_wheel1)
			&& $stable(duty_wheel2) && $stable(reverse_wheel2)
			&& $stable(duty_wheel3) && $stable(reverse_wheel3))
		else $error("stalled result changed");

	// the input only backs up when the whole pipe is full behind a stalled output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

	// an accepted transaction, or one ahead of it, must reach the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##6 out_valid)
		else $error("transaction did not reach the output");

endmodule

bind omni_wheel_drive_mixer owdm_checker u_owdm_checker (.*);

[test/tb_omni_wheel_drive_mixer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_omni_wheel_drive_mixer
// Self-checking bench for the omni wheel drive mixer. Headings go in through
// a queue-fed driver; an in-bench model of the heading fold, octant trig,
// wheel mixing and duty scaling predicts every result, and a monitor checks
// each result field by field. Phases sweep the register settings and the
// sender/receiver idling patterns, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_omni_wheel_drive_mixer;

	localparam int FRAC         = owdm_pkg::TRIG_FRAC_BITS_DEF;
	localparam int WHEEL_FRAC   = FRAC + owdm_pkg::ONE_SHIFT;
	localparam int PIPE_LATENCY = 6;
	localparam int HOLD_CYCLES  = 400;
	localparam int NUM_PHASES   = 11;
	localparam int RAND_PER_PH  = 145;

	// indexes the block decodes to nothing
	localparam logic [owdm_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [owdm_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// one result: four duty/direction pairs, wheel 0 in the low slot
	typedef struct packed {
		logic [3:0][owdm_pkg::DUTY_W-1:0] duty;
		logic [3:0]                       rev;
	} wheel_set_t;

	logic                           clk            = 1'b0;
	logic                           arst_n         = 1'b0;
	logic                           cfg_we         = 1'b0;
	logic [owdm_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
	logic [owdm_pkg::CFG_W-1:0]     cfg_data       = '0;
	logic                           in_valid       = 1'b0;
	logic                           in_stall;
	logic [owdm_pkg::HEADING_W-1:0] heading_tenths = '0;
	logic                           out_valid;
	logic                           out_stall      = 1'b0;
	logic [owdm_pkg::DUTY_W-1:0]    duty_wheel0, duty_wheel1, duty_wheel2, duty_wheel3;
	logic                           reverse_wheel0, reverse_wheel1;
	logic                           reverse_wheel2, reverse_wheel3;

	omni_wheel_drive_mixer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.heading_tenths (heading_tenths),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.duty_wheel0    (duty_wheel0),
		.reverse_wheel0 (reverse_wheel0),
		.duty_wheel1    (duty_wheel1),
		.reverse_wheel1 (reverse_wheel1),
		.duty_wheel2    (duty_wheel2),
		.reverse_wheel2 (reverse_wheel2),
		.duty_wheel3    (duty_wheel3),
		.reverse_wheel3 (reverse_wheel3)
	);

	// register shadow used by the predictor
	int arm_len_cfg  = 256;
	int rot_rate_cfg = 0;

	logic [owdm_pkg::HEADING_W-1:0] heading_q[$];   // headings waiting for the driver
	wheel_set_t                     mixed_q[$];     // predicted wheel outputs, oldest first
	int                             headings_issued = 0;
	int                             results_seen    = 0;
	int                             mismatch_count  = 0;
	int                             send_gap_pct    = 0;
	int                             recv_stall_pct  = 0;
	logic                           hold_arm        = 1'b0;
	logic                           hold_done       = 1'b0;
	int                             hold_left       = 0;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// clamp a Q30 series sum to [0, 1.0], then round half up to FRAC bits
	function automatic longint trig_to_frac(input longint acc);
		longint unsigned u;
		if (acc < 0)
			acc = 0;
		if (acc > longint'(owdm_pkg::ONE_Q30))
			acc = longint'(owdm_pkg::ONE_Q30);
		u = longint'(acc);
		return longint'((u + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
	endfunction

	// sine and cosine of t tenths of a degree, t within one octant
	function automatic void octant_trig(input int t, output longint sn, output longint cs);
		longint unsigned x, x2, term;
		longint          acc;
		x    = (longint'(t) * owdm_pkg::PI_Q30 + 64'd900) / 64'd1800;
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
		end
		sn   = trig_to_frac(acc);
		term = owdm_pkg::ONE_Q30;
		acc  = longint'(owdm_pkg::ONE_Q30);
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
			acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
		end
		cs   = trig_to_frac(acc);
	endfunction

	// full prediction for one heading under the current register shadow
	function automatic wheel_set_t mix_heading(input logic [owdm_pkg::HEADING_W-1:0] hd);
		int              ang, quad, rem;
		longint          s0, c0, cx, sy, rot;
		longint          w[4];
		longint unsigned mag, d;
		wheel_set_t      res;
		ang = int'(hd) - owdm_pkg::ANGLE_OFFSET;
		if (ang < 0)
			ang += owdm_pkg::FULL_TURN;
		else if (ang > owdm_pkg::FULL_TURN)
			ang -= owdm_pkg::FULL_TURN;
		if (ang == owdm_pkg::FULL_TURN)
			ang = 0;
		quad = ang / owdm_pkg::QUARTER_TURN;
		rem  = ang % owdm_pkg::QUARTER_TURN;
		// past the quadrant midpoint, mirror the angle and swap sine and cosine
		if (rem <= owdm_pkg::EIGHTH_TURN)
			octant_trig(rem, s0, c0);
		else
			octant_trig(owdm_pkg::QUARTER_TURN - rem, c0, s0);
		case (quad)
			0: begin
				cx = c0;  sy = s0;
			end
			1: begin
				cx = -s0; sy = c0;
			end
			2: begin
				cx = -c0; sy = -s0;
			end
			default: begin
				cx = s0;  sy = -c0;
			end
		endcase
		rot  = longint'(arm_len_cfg) * longint'(rot_rate_cfg) * (64'sd1 <<< FRAC);
		w[0] =  sy * (64'sd1 <<< owdm_pkg::ONE_SHIFT) + rot;
		w[1] = -cx * (64'sd1 <<< owdm_pkg::ONE_SHIFT) + rot;
		w[2] = -sy * (64'sd1 <<< owdm_pkg::ONE_SHIFT) + rot;
		w[3] =  cx * (64'sd1 <<< owdm_pkg::ONE_SHIFT) + rot;
		for (int i = 0; i < 4; i++) begin
			mag = (w[i] < 0) ? longint'(-w[i]) : longint'(w[i]);
			if (mag >= (64'd1 << WHEEL_FRAC))
				d = owdm_pkg::DUTY_MAX_DEF;
			else
				d = (mag * owdm_pkg::DUTY_MAX_DEF) >> WHEEL_FRAC;
			res.duty[i] = d[owdm_pkg::DUTY_W-1:0];
			res.rev[i]  = (w[i] < 0);
		end
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Reporting and configuration
	// ------------------------------------------------------------------------

	// count and print every mismatch
	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
	endtask

	// one write strobe; spare indexes leave the shadow untouched
	task automatic write_reg(input logic [owdm_pkg::CFG_IDX_W-1:0] idx,
		input logic [owdm_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			owdm_pkg::REG_ARM_LENGTH:    arm_len_cfg  = int'(val);
			owdm_pkg::REG_ROTATION_RATE: rot_rate_cfg = int'($signed(val));
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Clock, limit
	// ------------------------------------------------------------------------

	initial begin
		forever #10 clk = ~clk;
	end

	// generous ceiling; a correct run finishes far earlier
	initial begin
		#8_000_000;
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver: advance to the next queued heading once the current transaction
	// is taken, optionally idling first. Predict at acceptance.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid       <= 1'b0;
			heading_tenths <= '0;
		end else begin
			if (in_valid && !in_stall)
				mixed_q.push_back(mix_heading(heading_tenths));
			// hold the payload while stalled; otherwise load or drop valid
			if (!in_valid || !in_stall) begin
				if (heading_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					heading_tenths <= heading_q.pop_front();
					in_valid       <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Long output hold-off: counted here, armed once by the stimulus
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check each accepted result against the oldest prediction, then
	// pick the stall for the next cycle.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		wheel_set_t got, want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got.duty = {duty_wheel3, duty_wheel2, duty_wheel1, duty_wheel0};
				got.rev  = {reverse_wheel3, reverse_wheel2, reverse_wheel1, reverse_wheel0};
				if (mixed_q.size() == 0) begin
					report_mismatch("result with no heading pending", 1, 0);
				end else begin
					want = mixed_q.pop_front();
					results_seen++;
					for (int i = 0; i < 4; i++) begin
						if (got.duty[i] !== want.duty[i])
							report_mismatch($sformatf("duty_wheel%0d", i),
								int'(got.duty[i]), int'(want.duty[i]));
						if (got.rev[i] !== want.rev[i])
							report_mismatch($sformatf("reverse_wheel%0d", i),
								int'(got.rev[i]), int'(want.rev[i]));
					end
				end
			end
			out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus: reset, then one phase per register setting
	// ------------------------------------------------------------------------
	initial begin
		logic [owdm_pkg::HEADING_W-1:0] directed[$];
		idle_mode_t                     mode;
		int                             n_items;
		directed = '{
			12'd0, 12'd1, 12'd449, 12'd450, 12'd451, 12'd900, 12'd1349, 12'd1350,
			12'd1351, 12'd1800, 12'd2250, 12'd3150, 12'd3599, 12'd3600, 12'd4049,
			12'd4050, 12'd4051, 12'd4095, 12'd2048, 12'd1365, 12'd2730, 12'd675
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// drain, then let the pipeline settle before touching registers
			while (results_seen != headings_issued)
				@(posedge clk);
			repeat (PIPE_LATENCY + 2) @(posedge clk);

			case (ph)
				0: ;   // reset values: arm 1.0, no rotation
				1: begin
					write_reg(owdm_pkg::REG_ARM_LENGTH, 16'd0);
					write_reg(owdm_pkg::REG_ROTATION_RATE, 16'd0);
				end
				2: begin
					write_reg(owdm_pkg::REG_ARM_LENGTH, 16'hFFFF);
					write_reg(owdm_pkg::REG_ROTATION_RATE, 16'h7FFF);
					// spare indexes must not disturb either register
					write_reg(REG_SPARE_2, 16'($urandom));
					write_reg(REG_SPARE_3, 16'($urandom));
				end
				3: begin
					write_reg(owdm_pkg::REG_ROTATION_RATE, 16'h8000);
				end
				4: begin
					write_reg(owdm_pkg::REG_ARM_LENGTH, 16'd256);
					write_reg(owdm_pkg::REG_ROTATION_RATE, 16'd16384);
				end
				5: begin
					write_reg(owdm_pkg::REG_ROTATION_RATE, 16'(-16384));
					write_reg(REG_SPARE_2, 16'hFFFF);
				end
				default: begin
					// mostly moderate rotation so duties stay off the rails
					if ($urandom_range(0, 3) == 0)
						write_reg(owdm_pkg::REG_ARM_LENGTH, 16'($urandom));
					else
						write_reg(owdm_pkg::REG_ARM_LENGTH, 16'($urandom_range(0, 512)));
					if ($urandom_range(0, 3) == 0)
						write_reg(owdm_pkg::REG_ROTATION_RATE, 16'($urandom));
					else
						write_reg(owdm_pkg::REG_ROTATION_RATE,
							16'($urandom_range(0, 8192) - 4096));
				end
			endcase

			mode = idle_mode_t'(ph % 4);
			case (mode)
				IDLE_NONE: begin
					send_gap_pct = 0;  recv_stall_pct = 0;
				end
				IDLE_SEND: begin
					send_gap_pct = 62; recv_stall_pct = 0;
				end
				IDLE_RECV: begin
					send_gap_pct = 0;  recv_stall_pct = 62;
				end
				default: begin
					send_gap_pct = 9;  recv_stall_pct = 9;
				end
			endcase

			if (ph == 0) begin
				foreach (directed[i])
					heading_q.push_back(directed[i]);
				headings_issued += directed.size();
			end else begin
				n_items = RAND_PER_PH;
				for (int i = 0; i < n_items; i++) begin
					// mostly in-range headings, some from the wrapped top end
					if ($urandom_range(0, 9) == 0)
						heading_q.push_back(
							owdm_pkg::HEADING_W'($urandom_range(3600, 4095)));
					else
						heading_q.push_back(
							owdm_pkg::HEADING_W'($urandom_range(0, 3599)));
				end
				headings_issued += n_items;
			end

			// back the output up for a long stretch while the sender keeps going
			if (ph == 4) begin
				@(posedge clk);
				hold_arm <= 1'b1;
			end
		end

		while (results_seen != headings_issued)
			@(posedge clk);
		repeat (4 * PIPE_LATENCY) @(posedge clk);
		if (mixed_q.size() != 0)
			report_mismatch("predictions left without a result", 0, mixed_q.size());

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
hdl/owdm_pkg.sv
hdl/owdm_angle.sv
hdl/owdm_trig.sv
hdl/owdm_wheel.sv
hdl/omni_wheel_drive_mixer.sv
hdl/owdm_checker.sv
test/tb_omni_wheel_drive_mixer.sv
